// ===== hdl/mf3_pkg.sv =====
// Shared types, constants and sorting functions for the 3x3 median filter.
// No dependencies; mf3_if and the filter unit import this package, mf3_ram does not.
package mf3_pkg;

    localparam int PIX_W       = 8;
    localparam int DIM_W       = 11;
    localparam int COORD_W     = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int MAX_HEIGHT  = 1024;
    localparam int DESC_DEPTH  = 4;
    localparam int DESC_PTR_W  = 2;
    localparam int DESC_CNT_W  = 3;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;
    localparam logic [DIM_W-1:0] MIN_DIM      = 11'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef logic [PIX_W-1:0] pix_t;
    // Nine pixels; entry row*3+col, row 0 is the top row, col 0 the oldest column.
    typedef pix_t [8:0] pix9_t;

    // One window snapshot with everything needed to issue its results.
    typedef struct packed {
        pix9_t            win;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
        logic [DIM_W-1:0] wm1;
        logic             r_is1;
        logic             c_is1;
        logic [3:0]       mask;
    } desc_t;

    // One result on its way through the median pipeline.
    typedef struct packed {
        pix9_t              win;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } job_t;

    // Compare and swap: afterwards p[a] holds the smaller value.
    function automatic pix9_t cas(pix9_t p, logic [3:0] a, logic [3:0] b);
        pix9_t q;
        q = p;
        if (p[a] > p[b])
        begin
            q[a] = p[b];
            q[b] = p[a];
        end
        return q;
    endfunction

    // The 19-exchange median network, cut into three parts of three levels each.
    function automatic pix9_t med_stage_a(pix9_t p);
        pix9_t q;
        q = p;
        q = cas(q, 4'd1, 4'd2); q = cas(q, 4'd4, 4'd5); q = cas(q, 4'd7, 4'd8);
        q = cas(q, 4'd0, 4'd1); q = cas(q, 4'd3, 4'd4); q = cas(q, 4'd6, 4'd7);
        q = cas(q, 4'd1, 4'd2); q = cas(q, 4'd4, 4'd5); q = cas(q, 4'd7, 4'd8);
        return q;
    endfunction

    function automatic pix9_t med_stage_b(pix9_t p);
        pix9_t q;
        q = p;
        q = cas(q, 4'd0, 4'd3); q = cas(q, 4'd5, 4'd8); q = cas(q, 4'd4, 4'd7);
        q = cas(q, 4'd3, 4'd6); q = cas(q, 4'd1, 4'd4); q = cas(q, 4'd2, 4'd5);
        q = cas(q, 4'd4, 4'd7);
        return q;
    endfunction

    // The median ends up in entry 4.
    function automatic pix9_t med_stage_c(pix9_t p);
        pix9_t q;
        q = p;
        q = cas(q, 4'd4, 4'd2); q = cas(q, 4'd6, 4'd4); q = cas(q, 4'd4, 4'd2);
        return q;
    endfunction

    // Gathers the clamped neighborhood out of the window. The upper window uses
    // rows (r-2, r-1, r) with the top row replaced by the middle one on row 1;
    // the lower window repeats the bottom row. Columns are handled the same way.
    function automatic pix9_t select_window(pix9_t win, logic up, logic endc,
                                            logic r_is1, logic c_is1);
        logic [2:0][1:0] rs;
        logic [2:0][1:0] cs;
        logic [3:0]      src;
        logic [3:0]      dst;
        pix9_t           v;
        rs = up   ? {2'd2, 2'd1, (r_is1 ? 2'd1 : 2'd0)} : {2'd2, 2'd2, 2'd1};
        cs = endc ? {2'd2, 2'd2, 2'd1} : {2'd2, 2'd1, (c_is1 ? 2'd1 : 2'd0)};
        v  = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                src    = ({2'b00, rs[i]} * 4'd3) + {2'b00, cs[j]};
                dst    = 4'(i * 3 + j);
                v[dst] = win[src];
            end
        end
        return v;
    endfunction

endpackage

// ===== hdl/mf3_if.sv =====
// Channel interfaces of the median filter: configuration, pixel and result.
// Depends on mf3_pkg for field widths.
interface mf3_cfg_if import mf3_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface mf3_pix_if import mf3_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface mf3_res_if import mf3_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   median_value;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_column;
    logic               last_of_step;

    modport source (output valid, output median_value, output out_row,
                    output out_column, output last_of_step, input ready);
    modport sink   (input valid, input median_value, input out_row,
                    input out_column, input last_of_step, output ready);
endinterface

// ===== hdl/mf3_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module mf3_ram
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/median_filter_3x3_stream_unit.sv =====
// 3x3 median filter over a raster pixel stream; uses mf3_pkg, mf3_if, mf3_ram.
// Throughput: 1 pixel per cycle unless the snapshot queue is full; a pixel's
// results (2 on the last row or at a line end, 4 at the end of the last row)
// leave the single median pipeline one per cycle while the output moves.
// Reset: counters and window cleared, width 640, height 480; line store contents
// stay undefined, no clearing pass.
module median_filter_3x3_stream_unit
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic    clk,
    input  logic    rst_n,
    mf3_cfg_if.sink cfg,
    mf3_pix_if.sink pixels,
    mf3_res_if.source results
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; unknown indexes
    // are dropped.
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] frame_width_reg;
    logic [DIM_W-1:0] frame_height_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg.data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg.data;
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: position of the incoming pixel. Width and height are
    // saturated to their legal range, and a counter that lies past the
    // frame (after a register change) is taken as the last column or row.
    // The line store entry of the column is read in this cycle.
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] row_reg, row_next;
    logic [DIM_W-1:0] w_eff, h_eff, wm1, hm1, c_eff, r_eff;
    logic             eol, last_row, accept;
    logic [3:0]       mask;

    always_comb
    begin
        if (frame_width_reg < MIN_DIM)
            w_eff = MIN_DIM;
        else if (32'(frame_width_reg) > MAX_WIDTH)
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = frame_width_reg;

        if (frame_height_reg < MIN_DIM)
            h_eff = MIN_DIM;
        else if (32'(frame_height_reg) > MAX_HEIGHT)
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = frame_height_reg;

        wm1      = w_eff - 11'd1;
        hm1      = h_eff - 11'd1;
        c_eff    = (col_reg < wm1) ? col_reg : wm1;
        r_eff    = (row_reg < hm1) ? row_reg : hm1;
        eol      = (c_eff == wm1);
        last_row = (r_eff == hm1);

        // Which of the four possible results this pixel causes, in the order
        // they leave: upper middle, upper line end, lower middle, lower line end.
        if (r_eff != '0)
            mask = {last_row & eol, last_row & (c_eff != '0), eol, c_eff != '0};
        else
            mask = 4'b0000;

        if (eol)
        begin
            col_next = '0;
            row_next = last_row ? '0 : (r_eff + 11'd1);
        end
        else
        begin
            col_next = c_eff + 11'd1;
            row_next = r_eff;
        end
    end

    assign accept = pixels.valid & pixels.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Line stores: one RAM entry per column holds {row r-2, row r-1}.
    // A pixel reads its entry in stage 0 and writes {row r-1, new pixel}
    // back in the following cycle. Two pixels in a row never share a column while
    // the width is unchanged (it is at least two), so a read never meets the pending
    // write of the same entry and no forwarding is needed.
    // ------------------------------------------------------------------
    logic                s1_valid_reg;
    logic [PIX_W-1:0]    s1_px_reg;
    logic [ADDR_W-1:0]   s1_addr_reg;
    logic [DIM_W-1:0]    s1_row_reg, s1_col_reg, s1_wm1_reg;
    logic                s1_r_is1_reg, s1_c_is1_reg;
    logic [3:0]          s1_mask_reg;
    logic [2*PIX_W-1:0]  ram_rdata;

    mf3_ram
    #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    )
    u_line_ram
    (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_addr_reg),
        .wdata ({ram_rdata[PIX_W-1:0], s1_px_reg}),
        .re    (accept),
        .raddr (ADDR_W'(c_eff)),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg    <= pixels.pixel_in;
            s1_addr_reg  <= ADDR_W'(c_eff);
            s1_row_reg   <= r_eff;
            s1_col_reg   <= c_eff;
            s1_wm1_reg   <= wm1;
            s1_r_is1_reg <= (r_eff == 11'd1);
            s1_c_is1_reg <= (c_eff == 11'd1);
            s1_mask_reg  <= mask;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: the 3x3 window shifts one column and takes the two stored
    // rows plus the new pixel as its newest column.
    // ------------------------------------------------------------------
    pix9_t win_reg, win_next;

    always_comb
    begin
        win_next = win_reg;
        for (int i = 0; i < 3; i++)
        begin
            win_next[i * 3]     = win_reg[i * 3 + 1];
            win_next[i * 3 + 1] = win_reg[i * 3 + 2];
        end
        win_next[2] = ram_rdata[2*PIX_W-1:PIX_W];
        win_next[5] = ram_rdata[PIX_W-1:0];
        win_next[8] = s1_px_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else if (s1_valid_reg)
            win_reg <= win_next;
    end

    // ------------------------------------------------------------------
    // Snapshot queue. Every pixel that causes results leaves a snapshot of
    // its window here; the queue lets pixel transactions continue while
    // results wait at the output. The input stalls only when the queue,
    // counting the pixel still in stage 1, is full.
    // ------------------------------------------------------------------
    desc_t                 desc_mem_reg [DESC_DEPTH];
    logic [DESC_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [DESC_CNT_W-1:0] count_reg;
    desc_t                 desc_in, head;
    logic                  push, pop, head_valid;

    always_comb
    begin
        desc_in.win   = win_next;
        desc_in.row   = s1_row_reg;
        desc_in.col   = s1_col_reg;
        desc_in.wm1   = s1_wm1_reg;
        desc_in.r_is1 = s1_r_is1_reg;
        desc_in.c_is1 = s1_c_is1_reg;
        desc_in.mask  = s1_mask_reg;
    end

    assign push         = s1_valid_reg && (s1_mask_reg != 4'b0000);
    assign head         = desc_mem_reg[rd_ptr_reg];
    assign head_valid   = (count_reg != '0);
    assign pixels.ready = ((count_reg + {{(DESC_CNT_W-1){1'b0}}, s1_valid_reg})
                           < DESC_CNT_W'(DESC_DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
            desc_mem_reg[wr_ptr_reg] <= desc_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + {{(DESC_CNT_W-1){1'b0}}, push}
                                   - {{(DESC_CNT_W-1){1'b0}}, pop};
        end
    end

    // ------------------------------------------------------------------
    // Result issue: one result per cycle from the head snapshot, in mask
    // order, while the pipeline moves. done_reg records those already sent; the
    // snapshot leaves the queue with its final result, which carries last_of_step.
    // ------------------------------------------------------------------
    logic [3:0] done_reg, done_next;
    logic [3:0] remaining, pick, rest;
    logic       adv, issue, up, endc;
    job_t       job;

    always_comb
    begin
        remaining = head.mask & ~done_reg;
        pick      = remaining & (~remaining + 4'd1);
        rest      = remaining & ~pick;
        up        = pick[0] | pick[1];
        endc      = pick[1] | pick[3];
        issue     = head_valid && adv;
        pop       = issue && (rest == 4'b0000);

        if (pop)
            done_next = 4'b0000;
        else if (issue)
            done_next = done_reg | pick;
        else
            done_next = done_reg;

        job.win  = select_window(head.win, up, endc, head.r_is1, head.c_is1);
        job.row  = COORD_W'(up ? (head.row - 11'd1) : head.row);
        job.col  = COORD_W'(endc ? head.wm1 : (head.col - 11'd1));
        job.last = (rest == 4'b0000);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 4'b0000;
        else
            done_reg <= done_next;
    end

    // ------------------------------------------------------------------
    // Median pipeline: selection register, two sorting stages and the
    // output register, which holds a result until the sink takes it. The
    // whole pipeline moves whenever the output register is free or being
    // emptied.
    // ------------------------------------------------------------------
    logic  j_valid_reg, a_valid_reg, b_valid_reg, out_valid_reg;
    job_t  j_data_reg, a_data_reg, b_data_reg;
    job_t  a_in, b_in;
    pix9_t c_out;
    logic [PIX_W-1:0]   out_median_reg;
    logic [COORD_W-1:0] out_row_reg, out_col_reg;
    logic               out_last_reg;

    assign adv = !out_valid_reg || results.ready;

    always_comb
    begin
        a_in     = j_data_reg;
        a_in.win = med_stage_a(j_data_reg.win);
        b_in     = a_data_reg;
        b_in.win = med_stage_b(a_data_reg.win);
        c_out    = med_stage_c(b_data_reg.win);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_valid_reg   <= 1'b0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            j_valid_reg   <= issue;
            a_valid_reg   <= j_valid_reg;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            j_data_reg     <= job;
            a_data_reg     <= a_in;
            b_data_reg     <= b_in;
            out_median_reg <= c_out[4];
            out_row_reg    <= b_data_reg.row;
            out_col_reg    <= b_data_reg.col;
            out_last_reg   <= b_data_reg.last;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.median_value = out_median_reg;
    assign results.out_row      = out_row_reg;
    assign results.out_column   = out_col_reg;
    assign results.last_of_step = out_last_reg;

endmodule
